// File: rtl/aimd_pkg.sv
// shared types and constants for the aimd congestion window
`default_nettype none
package aimd_pkg;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_ACK  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    localparam logic [2:0] REG_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_HOLDOFF  = 3'd1;
    localparam logic [2:0] REG_MIN_WIN  = 3'd2;
    localparam logic [2:0] REG_START    = 3'd3;
    localparam logic [2:0] REG_STEP0    = 3'd4;
    localparam logic [2:0] REG_GROWTH   = 3'd5;
    localparam logic [2:0] REG_SCALE    = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_W      = 64;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] seq;
        logic [31:0] send_time;
        logic [31:0] now;
    } t_in_word;

    typedef struct packed {
        logic [15:0] window;
        logic        decreased;
        logic [8:0]  expired_count;
    } t_out_word;

    // handshake between the sequencer and the shared divider
    typedef struct packed {
        logic            start;
        logic [DIV_W-1:0] num;
        logic [31:0]     den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// File: rtl/aimd_congestion_window.sv
// aimd congestion window: top level with sequencer, entry tables and shared divider
// send writes the entry tables; an ack divides once for growth, or twice for a late cut (once when held off)
// tick: scans every entry, with a divide per expired entry and one more for a cut
// one item at a time; the 64-step divider is the shared unit that sets the pace
// reset is synchronous active low; TABLE_DEPTH valid bits clear at once, no sweep
// entry seq and time rams are not reset and are read only behind a valid bit
`default_nettype none
module aimd_congestion_window #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire  aimd_pkg::t_in_word i_data,
    output logic                     o_valid,
    input  wire                      i_stall,
    output aimd_pkg::t_out_word      o_data,
    input  wire                      i_cfg_we,
    input  wire  [aimd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [aimd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import aimd_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_ACK_RD, S_ACK_CHK, S_GROW_DIV, S_RATIO_WAIT, S_CUT_DIV,
        S_CUT_WAIT, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK, S_AGE_WAIT, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_timeout, r_holdoff, r_min_win, r_start;
    logic [23:0] r_step0, r_growth, r_scale;

    // architectural state
    logic [31:0] r_win;
    logic [23:0] r_step;
    logic [31:0] r_last_cut;
    logic [TABLE_DEPTH-1:0] r_vld;

    // per item
    t_in_word    r_in;
    logic [AW-1:0] r_addr;
    logic [23:0] r_maxr;
    logic [8:0]  r_exp;
    logic        r_cut;
    logic        r_last;
    t_out_word   r_out;
    logic        r_ovalid;

    // ram ports
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] seq_rd, time_rd;

    // divider
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic [15:0] eff_to;
    logic [31:0] rtt, age, floor_fx;
    logic [23:0] ratio_sat, step_sum;
    logic [32:0] win_sum;
    logic        held;
    logic        in_acc;

    assign eff_to   = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign floor_fx = {((r_min_win == 16'd0) ? 16'd1 : r_min_win), 16'd0};
    assign rtt      = r_in.now - r_in.send_time;
    assign age      = r_in.now - time_rd;
    assign held     = (r_in.now - r_last_cut) < {16'd0, r_holdoff};
    assign ratio_sat = (div_rsp.quo > 64'hFF_FFFF) ? 24'hFF_FFFF : div_rsp.quo[23:0];
    assign step_sum = ({1'b0, r_step} + {1'b0, r_growth} > 25'hFF_FFFF) ? 24'hFF_FFFF
                      : r_step + r_growth;
    assign win_sum  = {1'b0, r_win} + {1'b0, div_rsp.quo[31:0]};

    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // ram address: the item's slot, or the scan pointer on a tick
    always_comb begin
        ram_we   = 1'b0;
        ram_addr = r_addr;
        if (r_state == S_IDLE) begin
            ram_addr = i_data.seq[AW-1:0];
            ram_we   = in_acc && (i_data.action == ACT_SEND);
        end
    end

    aimd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_seq_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(i_data.seq), .o_rdata(seq_rd)
    );
    aimd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_time_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(i_data.send_time), .o_rdata(time_rd)
    );

    aimd_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // divider operands chosen by state
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = {16'd0, eff_to};
        unique case (r_state)
            S_ACK_CHK: begin
                div_req.num = {32'd0, rtt} * {40'd0, r_scale};
            end
            S_SCAN_CHK: begin
                div_req.num = {32'd0, age} * {40'd0, r_scale};
            end
            S_GROW_DIV: begin
                div_req.num = {24'd0, step_sum, 16'd0};
                div_req.den = (r_win == 32'd0) ? 32'd1 : r_win;
            end
            S_CUT_DIV: begin
                div_req.num = {16'd0, r_win, 16'd0};
                div_req.den = {8'd0, r_maxr};
            end
            default: ;
        endcase
        div_req.start = ((r_state == S_ACK_CHK) && r_vld[r_addr] && (seq_rd == r_in.seq)
                          && (rtt >= {16'd0, eff_to}))
                     || ((r_state == S_ACK_CHK) && r_vld[r_addr] && (seq_rd == r_in.seq)
                          && (rtt < {16'd0, eff_to}))
                     || ((r_state == S_SCAN_CHK) && r_vld[r_addr]
                          && (age > {16'd0, eff_to}))
                     || ((r_state == S_CUT_DIV) && !held && (r_maxr != 24'd0));
        if ((r_state == S_ACK_CHK) && (rtt < {16'd0, eff_to})) begin
            div_req.num = {24'd0, step_sum, 16'd0};
            div_req.den = (r_win == 32'd0) ? 32'd1 : r_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_timeout  <= 16'd90;
            r_holdoff  <= 16'd200;
            r_min_win  <= 16'd1;
            r_start    <= 16'd5;
            r_step0    <= 24'd65536;
            r_growth   <= 24'd655;
            r_scale    <= 24'd98304;
            r_win      <= {16'd5, 16'd0};
            r_step     <= 24'd65536;
            r_last_cut <= '0;
            r_vld      <= '0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                    REG_HOLDOFF: r_holdoff <= i_cfg_data[15:0];
                    REG_MIN_WIN: r_min_win <= i_cfg_data[15:0];
                    REG_START: begin
                        r_start <= i_cfg_data[15:0];
                        r_win   <= {((i_cfg_data[15:0] == 16'd0) ? 16'd1
                                     : i_cfg_data[15:0]), 16'd0};
                    end
                    REG_STEP0: begin
                        r_step0 <= i_cfg_data;
                        r_step  <= i_cfg_data;
                    end
                    REG_GROWTH: r_growth <= i_cfg_data;
                    REG_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in   <= i_data;
                        r_addr <= i_data.seq[AW-1:0];
                        r_cut  <= 1'b0;
                        r_exp  <= '0;
                        r_maxr <= 24'd65536;
                        unique case (t_action'(i_data.action))
                            ACT_SEND: begin
                                r_vld[i_data.seq[AW-1:0]] <= 1'b1;
                                r_state <= S_OUT;
                            end
                            ACT_ACK:  r_state <= S_ACK_RD;
                            ACT_TICK: begin
                                r_addr  <= '0;
                                r_state <= S_SCAN_RD;
                            end
                            default:  r_state <= S_OUT;
                        endcase
                    end
                end
                S_ACK_RD: r_state <= S_ACK_CHK;
                S_ACK_CHK: begin
                    if (r_vld[r_addr] && (seq_rd == r_in.seq)) begin
                        r_vld[r_addr] <= 1'b0;
                        if (rtt < {16'd0, eff_to}) begin
                            r_step  <= step_sum;
                            r_state <= S_GROW_DIV;
                        end else begin
                            r_state <= S_RATIO_WAIT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_GROW_DIV: begin
                    // wait for the gain step_fx / window
                    if (div_rsp.done) begin
                        r_win <= win_sum[32] ? 32'hFFFF_FFFF : win_sum[31:0];
                        r_state <= S_OUT;
                    end
                end
                S_RATIO_WAIT: begin
                    if (div_rsp.done) begin
                        r_maxr  <= ratio_sat;
                        r_state <= S_CUT_DIV;
                    end
                end
                S_CUT_DIV: begin
                    // cut attempt: step always resets, holdoff gates the rest
                    r_step <= r_step0;
                    if (held) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cut      <= 1'b1;
                        r_last_cut <= r_in.now;
                        if (r_maxr == 24'd0) begin
                            r_win   <= 32'hFFFF_FFFF;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CUT_WAIT;
                        end
                    end
                end
                S_CUT_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quo[63:32] != 32'd0) begin
                            r_win <= 32'hFFFF_FFFF;
                        end else if (div_rsp.quo[31:0] < floor_fx) begin
                            r_win <= floor_fx;
                        end else begin
                            r_win <= div_rsp.quo[31:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_WAIT;
                S_SCAN_WAIT: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    r_last <= (r_addr == AW'(TABLE_DEPTH - 1));
                    if (r_vld[r_addr] && (age > {16'd0, eff_to})) begin
                        r_vld[r_addr] <= 1'b0;
                        if (r_exp != 9'h1FF) begin
                            r_exp <= r_exp + 9'd1;
                        end
                        r_state <= S_AGE_WAIT;
                    end else if (r_addr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= (r_exp != 9'd0) ? S_CUT_DIV : S_OUT;
                    end else begin
                        r_addr  <= r_addr + AW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_AGE_WAIT: begin
                    // keep the largest scaled age ratio
                    if (div_rsp.done) begin
                        if (ratio_sat > r_maxr) begin
                            r_maxr <= ratio_sat;
                        end
                        if (r_last) begin
                            r_state <= S_CUT_DIV;
                        end else begin
                            r_addr  <= r_addr + AW'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_OUT: begin
                    r_out.window        <= r_win[31:16];
                    r_out.decreased     <= r_cut;
                    r_out.expired_count <= r_exp;
                    r_ovalid            <= 1'b1;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result word is only raised from the output step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result word raised outside the output step");

    // the divider is never restarted while it is still iterating
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> !div_req.start)
        else $error("divider restarted while busy");

    // the window never falls below the floor after an applied cut
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CUT_WAIT && $past(div_rsp.done)) |-> r_win >= floor_fx)
        else $error("window below floor after a cut");
endmodule
`default_nettype wire

// File: rtl/aimd_ram.sv
// generic single port ram with registered read
`default_nettype none
module aimd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: rtl/aimd_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module aimd_div (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  aimd_pkg::t_div_req i_req,
    output aimd_pkg::t_div_rsp      o_rsp
);
    import aimd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [32:0]      r_rem, n_rem;
    logic [31:0]      r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, r_done;
    logic [32:0]      trial;
    logic [33:0]      diff;

    always_comb begin
        trial = {r_rem[31:0], r_quo[DIV_W-1]};
        diff  = {1'b0, trial} - {2'b0, r_den};
        n_quo = {r_quo[DIV_W-2:0], 1'b0};
        n_rem = trial;
        if (!diff[33]) begin
            n_rem = diff[32:0];
            n_quo[0] = 1'b1;
        end
        n_cnt = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire
